### rtl/three_d_life_grid_defines.svh
// assertion macros for the life grid
`ifndef THREE_D_LIFE_GRID_DEFINES_SVH
`define THREE_D_LIFE_GRID_DEFINES_SVH
`define TDL_ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define TDL_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

### rtl/tdl_pkg.sv
package tdl_pkg;
    localparam int SIDE = 16;
    localparam int CW = $clog2(SIDE);
    localparam int CELLS = SIDE * SIDE * SIDE;
    localparam int AW = 3 * CW;
    localparam int POP_W = $clog2(CELLS + 1);
    localparam logic [12:0] POP_MAX = 13'd8191;

    typedef enum logic [1:0] {
        CMD_SET = 2'd0, CMD_CLEAR = 2'd1, CMD_ADVANCE = 2'd2, CMD_QUERY = 2'd3
    } t_cmd;

    localparam logic [1:0] REG_SL = 2'd0;
    localparam logic [1:0] REG_SH = 2'd1;
    localparam logic [1:0] REG_BL = 2'd2;
    localparam logic [1:0] REG_BH = 2'd3;

    typedef struct packed {
        logic [1:0] command;
        logic [3:0] x_coord;
        logic [3:0] y_coord;
        logic [3:0] z_coord;
    } t_in;

    typedef struct packed {
        logic        flag;
        logic [12:0] population;
    } t_out;

    typedef struct packed {
        logic [4:0] sl;
        logic [4:0] sh;
        logic [4:0] bl;
        logic [4:0] bh;
    } t_rules;
endpackage

### rtl/tdl_ram.sv
module tdl_ram #(
    parameter int AW = 12
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic          i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic          o_rdata
);
    logic mem [2**AW];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

### rtl/tdl_cfg.sv
module tdl_cfg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output tdl_pkg::t_rules     o_rules
);
    tdl_pkg::t_rules r_rules;
    logic wr;
    assign wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_rules = r_rules;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rules <= '{sl: 5'd4, sh: 5'd5, bl: 5'd5, bh: 5'd5};
        end else if (wr && paddr[1:0] == 2'b00) begin
            unique case (paddr[3:2])
                tdl_pkg::REG_SL: r_rules.sl <= pwdata[4:0];
                tdl_pkg::REG_SH: r_rules.sh <= pwdata[4:0];
                tdl_pkg::REG_BL: r_rules.bl <= pwdata[4:0];
                tdl_pkg::REG_BH: r_rules.bh <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = 32'd0;
        unique case (paddr[3:2])
            tdl_pkg::REG_SL: prdata[4:0] = r_rules.sl;
            tdl_pkg::REG_SH: prdata[4:0] = r_rules.sh;
            tdl_pkg::REG_BL: prdata[4:0] = r_rules.bl;
            tdl_pkg::REG_BH: prdata[4:0] = r_rules.bh;
            default: ;
        endcase
    end
endmodule

### rtl/tdl_core.sv
module tdl_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  tdl_pkg::t_in      i_cmd,
    input  tdl_pkg::t_rules   i_rules,
    output logic              o_busy,
    output logic              o_valid,
    output tdl_pkg::t_out     o_result
);
    localparam int CW = tdl_pkg::CW;
    localparam int AW = tdl_pkg::AW;
    localparam int PW = tdl_pkg::POP_W;
    localparam int NB = 27;
    localparam int OW = $clog2(NB + 2);

    // Two banks; r_bank picks which holds the current generation. Both banks
    // are zeroed by a clearing pass after reset.
    typedef enum logic [2:0] {S_CLR, S_IDLE, S_ACC, S_SCAN, S_WR, S_DONE} t_state;
    t_state r_state;

    logic            r_bank;
    logic [AW-1:0]   r_clr;
    logic [PW-1:0]   r_pop, r_npop;
    logic            r_valid;
    tdl_pkg::t_out   r_res;
    tdl_pkg::t_in    r_cmd;
    logic            r_inside;
    logic [AW-1:0]   r_cell;
    logic [OW-1:0]   r_off;
    logic [4:0]      r_cnt;
    logic            r_self;
    logic            r_prd_ok;

    logic            rd0, rd1;
    logic            we0, we1, wd0, wd1;
    logic [AW-1:0]   wa0, wa1, ra0, ra1;

    tdl_ram #(.AW(AW)) u_b0 (.i_clk, .i_we(we0), .i_waddr(wa0), .i_wdata(wd0),
        .i_raddr(ra0), .o_rdata(rd0));
    tdl_ram #(.AW(AW)) u_b1 (.i_clk, .i_we(we1), .i_waddr(wa1), .i_wdata(wd1),
        .i_raddr(ra1), .o_rdata(rd1));

    logic [CW-1:0] cx, cy, cz;
    logic [CW+1:0] nx, ny, nz;
    logic          n_ok;
    logic [1:0]    ox, oy, oz;
    logic [AW-1:0] naddr, caddr;
    logic          cur_rd;
    logic [4:0]    cnt_fin;
    logic          alive;

    assign {cx, cy, cz} = r_cell;
    // offset 0..26 split into three base-3 digits by compare and subtract
    always_comb begin
        logic [OW-1:0] t;
        t  = r_off;
        ox = 2'd0;
        if (t >= OW'(18)) begin
            ox = 2'd2;
            t  = t - OW'(18);
        end else if (t >= OW'(9)) begin
            ox = 2'd1;
            t  = t - OW'(9);
        end
        oy = 2'd0;
        if (t >= OW'(6)) begin
            oy = 2'd2;
            t  = t - OW'(6);
        end else if (t >= OW'(3)) begin
            oy = 2'd1;
            t  = t - OW'(3);
        end
        oz = t[1:0];
        nx = {2'b00, cx} + {{CW{1'b0}}, ox} - 1'b1;
        ny = {2'b00, cy} + {{CW{1'b0}}, oy} - 1'b1;
        nz = {2'b00, cz} + {{CW{1'b0}}, oz} - 1'b1;
        n_ok = (nx < (CW+2)'(tdl_pkg::SIDE)) && (ny < (CW+2)'(tdl_pkg::SIDE))
            && (nz < (CW+2)'(tdl_pkg::SIDE));
        naddr = {nx[CW-1:0], ny[CW-1:0], nz[CW-1:0]};
    end

    assign caddr = {i_cmd.x_coord[CW-1:0], i_cmd.y_coord[CW-1:0], i_cmd.z_coord[CW-1:0]};
    assign cur_rd = r_bank ? rd1 : rd0;

    always_comb begin
        ra0 = naddr;
        ra1 = naddr;
        if (r_state == S_IDLE) begin
            ra0 = caddr;
            ra1 = caddr;
        end
    end

    // data read last cycle belongs to neighbor (r_off-1), center is offset 13
    always_comb begin
        cnt_fin = r_cnt + ((r_prd_ok && !r_self) ? 5'(cur_rd) : 5'd0);
    end

    logic r_center;
    always_comb begin
        if (r_center)
            alive = (cnt_fin >= i_rules.sl) && (cnt_fin <= i_rules.sh);
        else
            alive = (cnt_fin >= i_rules.bl) && (cnt_fin <= i_rules.bh);
    end

    function automatic logic [12:0] sat(input logic [PW-1:0] v);
        logic [PW:0] w;
        w = {1'b0, v};
        if (w > (PW+1)'(tdl_pkg::POP_MAX)) return tdl_pkg::POP_MAX;
        return 13'(v);
    endfunction

    always_comb begin
        we0 = 1'b0; we1 = 1'b0; wd0 = 1'b0; wd1 = 1'b0;
        wa0 = r_cell; wa1 = r_cell;
        unique case (r_state)
            S_CLR: begin
                we0 = 1'b1; we1 = 1'b1; wa0 = r_clr; wa1 = r_clr;
            end
            S_ACC: begin
                if (r_inside && r_cmd.command == tdl_pkg::CMD_SET) begin
                    we0 = !r_bank; we1 = r_bank; wd0 = 1'b1; wd1 = 1'b1;
                end else if (r_inside && r_cmd.command == tdl_pkg::CMD_CLEAR) begin
                    we0 = !r_bank; we1 = r_bank;
                end
            end
            S_WR: begin
                we0 = r_bank; we1 = !r_bank; wd0 = alive; wd1 = alive;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_bank  <= 1'b0;
            r_pop   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= (r_state == S_ACC) || (r_state == S_DONE);
            unique case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (&r_clr) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_start) begin
                        r_cmd <= i_cmd;
                        r_inside <= (i_cmd.x_coord < 4'(tdl_pkg::SIDE))
                            && (i_cmd.y_coord < 4'(tdl_pkg::SIDE))
                            && (i_cmd.z_coord < 4'(tdl_pkg::SIDE))
                            || (tdl_pkg::SIDE >= 16);
                        if (i_cmd.command == tdl_pkg::CMD_ADVANCE) begin
                            r_cell <= '0; r_off <= '0; r_cnt <= '0;
                            r_prd_ok <= 1'b0; r_npop <= '0;
                            r_state <= S_SCAN;
                        end else begin
                            r_cell <= caddr;
                            r_state <= S_ACC;
                        end
                    end
                end
                S_ACC: begin
                    r_state <= S_IDLE;
                    if (r_inside) begin
                        unique case (r_cmd.command)
                            tdl_pkg::CMD_SET: begin
                                r_res.flag <= !cur_rd;
                                if (!cur_rd) r_pop <= r_pop + 1'b1;
                                r_res.population <= sat(r_pop + PW'(!cur_rd));
                            end
                            tdl_pkg::CMD_CLEAR: begin
                                r_res.flag <= cur_rd;
                                if (cur_rd) r_pop <= r_pop - 1'b1;
                                r_res.population <= sat(r_pop - PW'(cur_rd));
                            end
                            default: begin
                                r_res.flag <= cur_rd;
                                r_res.population <= sat(r_pop);
                            end
                        endcase
                    end else begin
                        r_res.flag <= 1'b0;
                        r_res.population <= sat(r_pop);
                    end
                end
                S_SCAN: begin
                    // issue read for r_off, accumulate data for r_off-1
                    r_prd_ok <= n_ok && r_off <= OW'(26);
                    r_self <= (r_off == OW'(13));
                    if (r_prd_ok) begin
                        if (r_self) r_center <= cur_rd;
                        else r_cnt <= r_cnt + 5'(cur_rd);
                    end
                    if (r_off == OW'(27)) r_state <= S_WR;
                    else r_off <= r_off + 1'b1;
                end
                S_WR: begin
                    r_npop <= r_npop + PW'(alive);
                    r_off <= '0; r_cnt <= '0; r_prd_ok <= 1'b0;
                    if (&r_cell) begin
                        r_state <= S_DONE;
                    end else begin
                        r_cell <= r_cell + 1'b1;
                        r_state <= S_SCAN;
                    end
                end
                S_DONE: begin
                    r_bank <= !r_bank;
                    r_pop <= r_npop;
                    r_res.flag <= 1'b0;
                    r_res.population <= sat(r_npop);
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_result = r_res;
endmodule

### rtl/three_d_life_grid.sv
// 3-D life grid, 16^3 cells in two one-bit RAM banks (current and next).
// After reset a clearing pass of both banks holds busy high. Set, clear and
// query do one RAM read, then write-back (set, clear) and result. Advance
// visits every cell, reading its 27-cell neighborhood one RAM read a cycle;
// the banks then swap roles. A result appears on o_result for one cycle
// with o_valid and cannot be stalled.
`include "three_d_life_grid_defines.svh"
module three_d_life_grid (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  tdl_pkg::t_in    i_cmd,
    output logic            o_valid,
    output tdl_pkg::t_out   o_result,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [3:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);
    tdl_pkg::t_rules rules;

    tdl_cfg u_cfg (.i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
        .prdata, .pready, .o_rules(rules));

    tdl_core u_core (.i_clk, .i_rst_n, .i_start(start), .i_cmd, .i_rules(rules),
        .o_busy(busy), .o_valid, .o_result);

    `TDL_ASSERT_NEXT(a_busy_after_start, i_clk, i_rst_n, start && !busy, busy)
    `TDL_ASSERT_IMPL(a_valid_when_idle, i_clk, i_rst_n, o_valid, !busy)
    `TDL_ASSERT_NEXT(a_single_strobe, i_clk, i_rst_n, o_valid, !o_valid)
endmodule

### test/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import tdl_pkg::*;

    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int GRID = 16;

    class life_scoreboard;
        bit          cells[GRID*GRID*GRID];
        int unsigned live;
        logic [4:0]  surv_lo, surv_hi, born_lo, born_hi;
        t_out        pending_q[$];
        int          errors;

        function new();
            live = 0;
            surv_lo = 5'd4;
            surv_hi = 5'd5;
            born_lo = 5'd5;
            born_hi = 5'd5;
            errors = 0;
        endfunction

        function void set_rule(logic [1:0] idx, logic [4:0] v);
            case (idx)
                REG_SL: surv_lo = v;
                REG_SH: surv_hi = v;
                REG_BL: born_lo = v;
                REG_BH: born_hi = v;
                default: ;
            endcase
        endfunction

        function int addr(int x, int y, int z);
            return (x * GRID + y) * GRID + z;
        endfunction

        function int count_around(int x, int y, int z);
            int n;
            n = 0;
            for (int dx = -1; dx <= 1; dx++)
                for (int dy = -1; dy <= 1; dy++)
                    for (int dz = -1; dz <= 1; dz++) begin
                        if (dx == 0 && dy == 0 && dz == 0) continue;
                        if (x+dx < 0 || y+dy < 0 || z+dz < 0) continue;
                        if (x+dx >= GRID || y+dy >= GRID || z+dz >= GRID) continue;
                        n += cells[addr(x+dx, y+dy, z+dz)];
                    end
            return n;
        endfunction

        function void step_generation();
            bit nxt[GRID*GRID*GRID];
            int n;
            int unsigned p;
            p = 0;
            for (int x = 0; x < GRID; x++)
                for (int y = 0; y < GRID; y++)
                    for (int z = 0; z < GRID; z++) begin
                        n = count_around(x, y, z);
                        if (cells[addr(x, y, z)])
                            nxt[addr(x, y, z)] = (n >= surv_lo && n <= surv_hi);
                        else
                            nxt[addr(x, y, z)] = (n >= born_lo && n <= born_hi);
                        p += nxt[addr(x, y, z)];
                    end
            cells = nxt;
            live = p;
        endfunction

        // note an accepted command and queue the result it must produce
        function void note(t_in it);
            t_out r;
            int   i;
            r.flag = 1'b0;
            i = addr(it.x_coord, it.y_coord, it.z_coord);
            case (it.command)
                CMD_ADVANCE: step_generation();
                CMD_SET: if (!cells[i]) begin
                    cells[i] = 1'b1;
                    live++;
                    r.flag = 1'b1;
                end
                CMD_CLEAR: if (cells[i]) begin
                    cells[i] = 1'b0;
                    live--;
                    r.flag = 1'b1;
                end
                default: r.flag = cells[i];
            endcase
            r.population = (live > 8191) ? 13'd8191 : live[12:0];
            pending_q.insert(pending_q.size(), r);
        endfunction

        task report(string msg);
            $display("[%0t] error: %s", $realtime, msg);
            errors++;
        endtask

        task check(t_out got);
            t_out want;
            if (pending_q.size() == 0) begin
                report($sformatf("unexpected result flag=%0b pop=%0d",
                                 got.flag, got.population));
            end else begin
                want = pending_q.pop_front();
                if (got.flag !== want.flag)
                    report($sformatf("flag %0b, expected %0b", got.flag, want.flag));
                if (got.population !== want.population)
                    report($sformatf("population %0d, expected %0d",
                                     got.population, want.population));
            end
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_in         i_cmd;
    logic        o_valid;
    t_out        o_result;
    logic        psel, penable, pwrite, pready;
    logic [3:0]  paddr;
    logic [31:0] pwdata, prdata;

    life_scoreboard grid_sb;
    int  cycles;
    bit  gaps_on;
    int  corner;

    three_d_life_grid u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cmd(i_cmd), .o_valid(o_valid), .o_result(o_result),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) grid_sb.check(o_result);
    end

    // start stays high across back-to-back transfers; only pause and drain lower it
    task send(t_cmd c, logic [3:0] x, logic [3:0] y, logic [3:0] z);
        t_in it;
        bit  taken;
        it.command = c;
        it.x_coord = x;
        it.y_coord = y;
        it.z_coord = z;
        start <= 1'b1;
        i_cmd <= it;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = !busy;
            @(posedge i_clk);
        end
        grid_sb.note(it);
    endtask

    task pause(int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task drain();
        start <= 1'b0;
        while (grid_sb.pending_q.size() != 0) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // psel stays high between writes; load_rules drops it after the last one
    task write_rule(logic [1:0] idx, logic [31:0] v);
        bit done;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        done = 1'b0;
        while (!done) begin
            @(negedge i_clk);
            done = pready;
            @(posedge i_clk);
        end
        grid_sb.set_rule(idx, v[4:0]);
    endtask

    task load_rules(logic [4:0] sl, logic [4:0] sh, logic [4:0] bl, logic [4:0] bh);
        drain();
        write_rule(REG_SL, {27'h5a5a5a5, sl});
        write_rule(REG_SH, {27'h0, sh});
        write_rule(REG_BL, {27'h7ffffff, bl});
        write_rule(REG_BH, {27'h0, bh});
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // mostly cluster near one base point (0, 6 or 12) so generations have live neighborhoods
    function logic [3:0] pick_coord();
        if ($urandom_range(0, 4) == 0) return 4'($urandom_range(0, 15));
        return 4'(corner + $urandom_range(0, 3));
    endfunction

    task random_items(int n);
        int    r;
        t_cmd  c;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            c = (r < 45) ? CMD_SET : (r < 65) ? CMD_CLEAR : CMD_QUERY;
            send(c, pick_coord(), pick_coord(), pick_coord());
            if (gaps_on && $urandom_range(0, 4) == 0) pause($urandom_range(1, 12));
        end
    endtask

    initial begin
        grid_sb = new();
        cycles  = 0;
        gaps_on = 1'b1;
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_cmd   = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: corners, repeat set/clear, a small cluster, one generation
        send(CMD_SET,   4'd0,  4'd0,  4'd0);
        send(CMD_SET,   4'd0,  4'd0,  4'd0);
        send(CMD_QUERY, 4'd0,  4'd0,  4'd0);
        send(CMD_QUERY, 4'd15, 4'd15, 4'd15);
        send(CMD_SET,   4'd15, 4'd15, 4'd15);
        send(CMD_CLEAR, 4'd15, 4'd15, 4'd15);
        send(CMD_CLEAR, 4'd15, 4'd15, 4'd15);
        send(CMD_SET,   4'd1,  4'd0,  4'd0);
        send(CMD_SET,   4'd0,  4'd1,  4'd0);
        send(CMD_SET,   4'd1,  4'd1,  4'd0);
        send(CMD_SET,   4'd0,  4'd0,  4'd1);
        send(CMD_SET,   4'd1,  4'd0,  4'd1);
        send(CMD_SET,   4'd10, 4'd5,  4'd10);
        send(CMD_SET,   4'd5,  4'd10, 4'd5);
        send(CMD_ADVANCE, 4'd15, 4'd15, 4'd15);
        send(CMD_QUERY, 4'd0,  4'd0,  4'd0);
        send(CMD_QUERY, 4'd1,  4'd1,  4'd1);
        send(CMD_QUERY, 4'd0,  4'd1,  4'd1);
        send(CMD_CLEAR, 4'd10, 4'd5,  4'd10);
        send(CMD_QUERY, 4'd5,  4'd10, 4'd5);

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: load_rules(5'd4,  5'd5,  5'd5,  5'd5);
                1: load_rules(5'd0,  5'd26, 5'd0,  5'd0);   // zero in birth range
                2: load_rules(5'd2,  5'd6,  5'd3,  5'd4);
                3: load_rules(5'd6,  5'd3,  5'd27, 5'd31);  // empty ranges
                4: load_rules(5'd0,  5'd31, 5'd1,  5'd26);
                default: load_rules(5'd26, 5'd26, 5'd26, 5'd26);
            endcase
            gaps_on = (ph != 5);
            corner  = ($urandom_range(0, 2) == 0) ? 0 : ($urandom_range(0, 1) ? 12 : 6);
            random_items(100);
            send(CMD_ADVANCE, 4'($urandom), 4'($urandom), 4'($urandom));
            random_items(20);
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (grid_sb.errors == 0 && grid_sb.pending_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
